>>> rtl/modexp_pkg.sv
// Shared types and constants for the modular exponentiation core.
package modexp_pkg;

  // Width of the signed base word.
  localparam int BASE_W = 32;

  // Width of the magnitude of the base, which can reach two to the power (BASE_W - 1).
  localparam int MAG_W = BASE_W + 1;

  // Width of the bit counter inside the serial multiplier.
  localparam int CNT_W = $clog2(MAG_W + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_STEP,
    S_MUL,
    S_OUT
  } state_t;

endpackage

>>> rtl/modexp_mulser.sv
// Bit-serial modular multiplier: scans x from its top bit, one bit per cycle.
module modexp_mulser
  import modexp_pkg::*;
#(
  parameter int MOD_BITS = 31
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [MAG_W-1:0]    x,
  input  logic [MOD_BITS-1:0] y,
  input  logic [MOD_BITS-1:0] m,
  output logic                done,
  output logic [MOD_BITS-1:0] prod
);

  localparam int RW = MOD_BITS + 2;

  logic                run_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [MAG_W-1:0]    x_r;
  logic [MOD_BITS-1:0] y_r;
  logic [MOD_BITS-1:0] m_r;
  logic [MOD_BITS-1:0] r_r;
  logic [MOD_BITS-1:0] r_nxt;
  logic [RW-1:0]       t;
  logic [RW:0]         d1;
  logic [RW:0]         d2;

  // The partial remainder stays below m, and y is at most m, so the doubled
  // value plus y stays below three times m: one of t, t-m and t-2m is in range.
  always_comb begin
    t  = {1'b0, r_r, 1'b0} + (x_r[MAG_W-1] ? RW'(y_r) : RW'(0));
    d1 = {1'b0, t} - (RW + 1)'(m_r);
    d2 = {1'b0, t} - (RW + 1)'({m_r, 1'b0});
    if (!d2[RW]) begin
      r_nxt = d2[MOD_BITS-1:0];
    end else if (!d1[RW]) begin
      r_nxt = d1[MOD_BITS-1:0];
    end else begin
      r_nxt = t[MOD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= run_r && (cnt_r == CNT_W'(1));
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && (cnt_r == CNT_W'(1))) begin
        run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x;
      y_r   <= y;
      m_r   <= m;
      r_r   <= '0;
      cnt_r <= CNT_W'(MAG_W);
    end else if (run_r) begin
      x_r   <= {x_r[MAG_W-2:0], 1'b0};
      r_r   <= r_nxt;
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign done = done_r;
  assign prod = r_r;

endmodule

>>> rtl/modular_exponentiation_core.sv
// Top level of the modular exponentiation core.
// Usage: raise start for one cycle while busy is low; the word on in_action,
// in_base, in_exponent and in_modulus is taken at that clock edge. Action zero
// computes base to the exponent modulo the modulus; action one computes the
// Fermat inverse, using the modulus minus two as the exponent. The signed base
// is first reduced into the range from zero to the modulus minus one.
// Exactly one result word follows each accepted word: out_result is valid for
// the single cycle in which out_valid is high. The receiver cannot stall the
// core, so it must take the word in that cycle. busy stays high from the
// accepting edge until out_valid has been shown.
// For a zero modulus, or an inverse with modulus one, out_valid is high in the
// cycle right after the accepting edge. Otherwise unit A first reduces the base,
// then for each exponent bit up to the highest set one the controller passes
// through S_STEP and S_MUL, and one more S_STEP sees the exhausted exponent
// before S_OUT raises out_valid. A new word can be taken once the core is back
// in idle, after out_valid has been shown. The run time is set by the bit-serial
// multipliers: each product scans 33 bits of one operand, one bit per cycle,
// with the multiply and the square side by side.
// Reset (synchronous, active low) returns the controller to idle; any word in
// progress is dropped and no result is produced for it.
module modular_exponentiation_core
  import modexp_pkg::*;
#(
  parameter int MOD_BITS = 31,
  parameter int EXP_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_action,
  input  logic signed [BASE_W-1:0] in_base,
  input  logic [EXP_BITS-1:0]      in_exponent,
  input  logic [MOD_BITS-1:0]      in_modulus,
  output logic                     out_valid,
  output logic [MOD_BITS-1:0]      out_result
);

  // The exponent register must hold either the given exponent or modulus
  // minus two, whichever is wider.
  localparam int EW = (EXP_BITS > MOD_BITS) ? EXP_BITS : MOD_BITS;

  state_t              state_r;
  state_t              state_nxt;
  logic [MOD_BITS-1:0] m_r;
  logic [MOD_BITS-1:0] b_r;
  logic [MOD_BITS-1:0] acc_r;
  logic [MOD_BITS-1:0] res_r;
  logic [EW-1:0]       e_r;
  logic                neg_r;

  logic                accept;
  logic                early;
  logic                go_red;
  logic                go_mul;
  logic [MAG_W-1:0]    mag;
  logic [MAG_W-1:0]    x_a;
  logic [MOD_BITS-1:0] y_a;
  logic [MOD_BITS-1:0] m_a;
  logic                done_a;
  logic                done_b;
  logic [MOD_BITS-1:0] prod_a;
  logic [MOD_BITS-1:0] prod_b;

  assign accept = start && (state_r == S_IDLE);

  // A zero modulus gives zero, and an inverse with modulus one has a negative
  // exponent and gives one; neither needs the arithmetic units.
  assign early = (in_modulus == '0) ||
                 (in_action && (in_modulus == MOD_BITS'(1)));

  // Magnitude of the base; for a negative base it is two's complement negated.
  always_comb begin
    if (in_base[BASE_W-1]) begin
      mag = {1'b1, {BASE_W{1'b0}}} - {1'b0, in_base};
    end else begin
      mag = {1'b0, in_base};
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = early ? S_OUT : S_RED;
        end
      end
      S_RED: begin
        if (done_a) begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        state_nxt = (e_r == '0) ? S_OUT : S_MUL;
      end
      S_MUL: begin
        if (done_a) begin
          state_nxt = S_STEP;
        end
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Controller outputs.
  always_comb begin
    busy      = 1'b1;
    out_valid = 1'b0;
    go_red    = 1'b0;
    go_mul    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        busy   = 1'b0;
        go_red = start && !early;
      end
      S_STEP: begin
        go_mul = (e_r != '0);
      end
      S_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Unit A first reduces the magnitude of the base (a product with one), then
  // forms accumulator times base for each exponent bit. Unit B squares the base.
  assign x_a = go_red ? mag : MAG_W'(acc_r);
  assign y_a = go_red ? MOD_BITS'(1) : b_r;
  assign m_a = go_red ? in_modulus : m_r;

  modexp_mulser #(
    .MOD_BITS(MOD_BITS)
  ) u_mul_a (
    .clk  (clk),
    .rst_n(rst_n),
    .start(go_red || go_mul),
    .x    (x_a),
    .y    (y_a),
    .m    (m_a),
    .done (done_a),
    .prod (prod_a)
  );

  modexp_mulser #(
    .MOD_BITS(MOD_BITS)
  ) u_mul_b (
    .clk  (clk),
    .rst_n(rst_n),
    .start(go_mul),
    .x    (MAG_W'(b_r)),
    .y    (b_r),
    .m    (m_r),
    .done (done_b),
    .prod (prod_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers. The exponent is scanned from its low bit; a set bit
  // folds the running square into the accumulator.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          m_r   <= in_modulus;
          neg_r <= in_base[BASE_W-1];
          e_r   <= in_action ? EW'(in_modulus - MOD_BITS'(2)) : EW'(in_exponent);
          res_r <= (in_modulus == '0) ? '0 : MOD_BITS'(1);
        end
      end
      S_RED: begin
        if (done_a) begin
          if (neg_r && (prod_a != '0)) begin
            b_r <= m_r - prod_a;
          end else begin
            b_r <= prod_a;
          end
          acc_r <= MOD_BITS'(1);
        end
      end
      S_STEP: begin
        if (e_r == '0) begin
          res_r <= acc_r;
        end
      end
      S_MUL: begin
        if (done_a && done_b) begin
          if (e_r[0]) begin
            acc_r <= prod_a;
          end
          b_r <= prod_b;
          e_r <= e_r >> 1;
        end
      end
      default: begin
        res_r <= res_r;
      end
    endcase
  end

  assign out_result = res_r;

endmodule
